@@ hw/rtl/tss_pkg.sv @@
// tss_pkg: shared constants and types for the three-value sum search block
// no dependencies
`timescale 1ns / 1ps

package tss_pkg;
	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int VALUE_WIDTH_DEF  = 16;
	localparam int TARGET_WIDTH     = 18;
	localparam int INDEX_OUT_WIDTH  = 6;

	typedef enum logic [13:0] {
		ST_LOAD     = 14'b00000000000001,
		ST_KEY_RD   = 14'b00000000000010,
		ST_KEY_LD   = 14'b00000000000100,
		ST_SORT_RD  = 14'b00000000001000,
		ST_SORT_CMP = 14'b00000000010000,
		ST_SORT_WR  = 14'b00000000100000,
		ST_PAIR_I   = 14'b00000001000000,
		ST_PAIR_J   = 14'b00000010000000,
		ST_PAIR_CHK = 14'b00000100000000,
		ST_BS_RD    = 14'b00001000000000,
		ST_BS_CMP   = 14'b00010000000000,
		ST_FIN_RD   = 14'b00100000000000,
		ST_FIN_CHK  = 14'b01000000000000,
		ST_OUT      = 14'b10000000000000
	} tss_state_t;
endpackage

@@ hw/rtl/three_sum_search_top.sv @@
// three_sum_search_top: loads signed values, sorts them and searches for a
// triple that reaches the target sum; uses tss_pkg
//
// Values load one beat per cycle into an internal memory. A beat with tlast
// starts insertion sort if more than one value is held: each element pass
// reads its key, then reads and compares element by element (every move costs
// one compare, and a pass that stops on a value not greater costs one more).
// The pair walk reads each pair, then probes and a final read if it is searched.
// The single memory read port sets the pace; s_tready is low from the last
// beat until the result beat is taken. m_tdata fields from bit 0 up:
// found, index_first, index_second, index_third, overflow.
`timescale 1ns / 1ps

module three_sum_search_top #(
	parameter int MAX_ELEMENTS = tss_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = tss_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic signed [tss_pkg::TARGET_WIDTH-1:0] cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,  // value
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [23:0]                            m_tdata   // found, idx x3, overflow
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = AW;
	localparam int SW = ((tss_pkg::TARGET_WIDTH > VALUE_WIDTH + 1) ?
		tss_pkg::TARGET_WIDTH : VALUE_WIDTH + 1) + 1;
	localparam int OW = tss_pkg::INDEX_OUT_WIDTH;

	logic signed [VALUE_WIDTH-1:0] val_mem [MAX_ELEMENTS];
	logic [IW-1:0]                 idx_mem [MAX_ELEMENTS];
	logic signed [VALUE_WIDTH-1:0] rd_val_q;
	logic [IW-1:0]                 rd_idx_q;

	tss_pkg::tss_state_t state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic signed [tss_pkg::TARGET_WIDTH-1:0] target_q;

	logic [CW-1:0] i_q, k_q, j_q, lo_q, hi_q;
	logic signed [VALUE_WIDTH-1:0] key_v_q, vi_q;
	logic [IW-1:0] key_i_q, ii_q, ij_q;
	logic signed [SW-1:0] need_q;
	logic found_q;
	logic [OW-1:0] r0_q, r1_q, r2_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic signed [VALUE_WIDTH-1:0] wval;
	logic [IW-1:0] widx;
	logic [CW-1:0] mid;
	logic [CW-1:0] n_load;
	logic [CW:0]   n_x, i_p3, j_p2;
	logic signed [SW-1:0] need_d;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign n_load = (count_q < CW'(MAX_ELEMENTS)) ? count_q + 1'b1 : count_q;
	assign n_x = {1'b0, count_q};
	assign i_p3 = {1'b0, i_q} + (CW+1)'(3);
	assign j_p2 = {1'b0, j_q} + (CW+1)'(2);
	assign need_d = SW'(target_q) - (SW'(vi_q) + SW'(rd_val_q));
	assign s_tready = (state_q == tss_pkg::ST_LOAD);
	assign m_tvalid = (state_q == tss_pkg::ST_OUT);
	assign m_tdata = {4'd0, ovf_q, r2_q, r1_q, r0_q, found_q};

	always_comb begin
		we = 1'b0;
		waddr = count_q[AW-1:0];
		wval = s_tdata[VALUE_WIDTH-1:0];
		widx = count_q[IW-1:0];
		raddr = '0;
		case (state_q)
			tss_pkg::ST_LOAD: begin
				we = s_tvalid && (count_q < CW'(MAX_ELEMENTS));
			end
			tss_pkg::ST_KEY_RD: raddr = i_q[AW-1:0];
			tss_pkg::ST_SORT_RD: raddr = AW'(k_q - 1'b1);
			tss_pkg::ST_SORT_CMP: begin
				if (rd_val_q > key_v_q) begin
					we = 1'b1;
					waddr = k_q[AW-1:0];
					wval = rd_val_q;
					widx = rd_idx_q;
				end
			end
			tss_pkg::ST_SORT_WR: begin
				we = 1'b1;
				waddr = k_q[AW-1:0];
				wval = key_v_q;
				widx = key_i_q;
			end
			tss_pkg::ST_PAIR_I: raddr = i_q[AW-1:0];
			tss_pkg::ST_PAIR_J: raddr = j_q[AW-1:0];
			tss_pkg::ST_BS_RD: raddr = mid[AW-1:0];
			tss_pkg::ST_FIN_RD: raddr = (lo_q < count_q) ? lo_q[AW-1:0] : '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			val_mem[waddr] <= wval;
			idx_mem[waddr] <= widx;
		end
		rd_val_q <= val_mem[raddr];
		rd_idx_q <= idx_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			found_q <= 1'b0;
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			i_q <= '0;
			k_q <= '0;
			j_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			key_v_q <= '0;
			key_i_q <= '0;
			vi_q <= '0;
			ii_q <= '0;
			ij_q <= '0;
			need_q <= '0;
		end else begin
			case (state_q)
				tss_pkg::ST_LOAD: begin
					if (s_tvalid) begin
						if (count_q < CW'(MAX_ELEMENTS)) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
						if (s_tlast) begin
							found_q <= 1'b0;
							r0_q <= '0;
							r1_q <= '0;
							r2_q <= '0;
							i_q <= CW'(1);
							state_q <= (n_load > CW'(1)) ? tss_pkg::ST_KEY_RD
								: tss_pkg::ST_OUT;
						end
					end
				end
				tss_pkg::ST_KEY_RD: state_q <= tss_pkg::ST_KEY_LD;
				tss_pkg::ST_KEY_LD: begin
					key_v_q <= rd_val_q;
					key_i_q <= rd_idx_q;
					k_q <= i_q;
					state_q <= tss_pkg::ST_SORT_RD;
				end
				tss_pkg::ST_SORT_RD: state_q <= tss_pkg::ST_SORT_CMP;
				tss_pkg::ST_SORT_CMP: begin
					if (rd_val_q > key_v_q) begin
						k_q <= k_q - 1'b1;
						state_q <= (k_q == CW'(1)) ? tss_pkg::ST_SORT_WR
							: tss_pkg::ST_SORT_RD;
					end else begin
						state_q <= tss_pkg::ST_SORT_WR;
					end
				end
				tss_pkg::ST_SORT_WR: begin
					if (i_q + 1'b1 < count_q) begin
						i_q <= i_q + 1'b1;
						state_q <= tss_pkg::ST_KEY_RD;
					end else begin
						i_q <= '0;
						state_q <= (count_q > CW'(2)) ? tss_pkg::ST_PAIR_I : tss_pkg::ST_OUT;
					end
				end
				tss_pkg::ST_PAIR_I: begin
					j_q <= i_q + 1'b1;
					state_q <= tss_pkg::ST_PAIR_J;
				end
				tss_pkg::ST_PAIR_J: begin
					if (j_q == i_q + 1'b1) begin
						vi_q <= rd_val_q;
						ii_q <= rd_idx_q;
					end
					state_q <= tss_pkg::ST_PAIR_CHK;
				end
				tss_pkg::ST_PAIR_CHK: begin
					ij_q <= rd_idx_q;
					need_q <= need_d;
					if (need_d < SW'(rd_val_q) || j_q + 1'b1 >= count_q) begin
						if (i_p3 < n_x) begin
							i_q <= i_q + 1'b1;
							state_q <= tss_pkg::ST_PAIR_I;
						end else begin
							state_q <= tss_pkg::ST_OUT;
						end
					end else begin
						lo_q <= j_q + 1'b1;
						hi_q <= count_q;
						state_q <= tss_pkg::ST_BS_RD;
					end
				end
				tss_pkg::ST_BS_RD: begin
					state_q <= (lo_q < hi_q) ? tss_pkg::ST_BS_CMP : tss_pkg::ST_FIN_RD;
				end
				tss_pkg::ST_BS_CMP: begin
					if (SW'(rd_val_q) < need_q) lo_q <= mid + 1'b1;
					else hi_q <= mid;
					state_q <= tss_pkg::ST_BS_RD;
				end
				tss_pkg::ST_FIN_RD: state_q <= tss_pkg::ST_FIN_CHK;
				tss_pkg::ST_FIN_CHK: begin
					if (lo_q < count_q && SW'(rd_val_q) == need_q) begin
						found_q <= 1'b1;
						r0_q <= OW'(ii_q);
						r1_q <= OW'(ij_q);
						r2_q <= OW'(rd_idx_q);
						state_q <= tss_pkg::ST_OUT;
					end else if (j_p2 < n_x) begin
						j_q <= j_q + 1'b1;
						state_q <= tss_pkg::ST_PAIR_J;
					end else if (i_p3 < n_x) begin
						i_q <= i_q + 1'b1;
						state_q <= tss_pkg::ST_PAIR_I;
					end else begin
						state_q <= tss_pkg::ST_OUT;
					end
				end
				tss_pkg::ST_OUT: begin
					if (m_tready) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= tss_pkg::ST_LOAD;
					end
				end
				default: state_q <= tss_pkg::ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("count beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("load while result pending");
endmodule

@@ verif/tb_three_sum_search_top.sv @@
// tb_three_sum_search_top: self-checking bench for the block, directed and random sets
// checked against a built-in sort-and-search predictor; uses tss_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_three_sum_search_top;
	localparam int NMAX = tss_pkg::MAX_ELEMENTS_DEF;

	typedef struct packed {
		logic signed [tss_pkg::VALUE_WIDTH_DEF-1:0] value;
		logic                                       last;
	} elem_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx_a;
		logic [5:0] idx_b;
		logic [5:0] idx_c;
		logic       ovf;
	} triple_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic signed [tss_pkg::TARGET_WIDTH-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;

	three_sum_search_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	elem_t   elem_q[$];
	triple_t triple_q[$];
	int      send_idle = 0;
	int      recv_idle = 0;
	int      hold_kick = 0;
	int      hold_seen = 0;
	int      hold_left = 0;
	int      mismatches = 0;
	logic    in_took = 1'b0;

	// predictor state
	int signed   want_sum = 0;
	int signed   set_val[NMAX];
	int          set_idx[NMAX];
	int          set_cnt = 0;
	logic        set_ovf = 1'b0;

	function automatic void predict_triple(elem_t e);
		int signed vv[NMAX];
		int ii[NMAX];
		int n, k, tv, ti, i, j, p;
		int signed need;
		triple_t r;
		if (set_cnt < NMAX) begin
			set_val[set_cnt] = e.value;
			set_idx[set_cnt] = set_cnt;
			set_cnt++;
		end else begin
			set_ovf = 1'b1;
		end
		if (!e.last)
			return;
		n = set_cnt;
		vv = set_val;
		ii = set_idx;
		for (i = 1; i < n; i++) begin
			tv = vv[i];
			ti = ii[i];
			k = i;
			while (k > 0 && vv[k-1] > tv) begin
				vv[k] = vv[k-1];
				ii[k] = ii[k-1];
				k--;
			end
			vv[k] = tv;
			ii[k] = ti;
		end
		r = '0;
		for (i = 0; i < n && !r.found; i++) begin
			for (j = i + 1; j < n; j++) begin
				need = want_sum - (vv[i] + vv[j]);
				if (need < vv[j])
					break;
				for (p = j + 1; p < n; p++)
					if (vv[p] == need)
						break;
				if (p < n) begin
					r.found = 1'b1;
					r.idx_a = ii[i][5:0];
					r.idx_b = ii[j][5:0];
					r.idx_c = ii[p][5:0];
					break;
				end
			end
		end
		r.ovf = set_ovf;
		triple_q.push_back(r);
		set_cnt = 0;
		set_ovf = 1'b0;
	endfunction

	// input side: predict on accepted beat
	always @(posedge clk) begin
		elem_t acc;
		in_took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			acc.value = s_tdata;
			acc.last = s_tlast;
			predict_triple(acc);
		end
	end

	// driver
	always @(negedge clk) begin
		elem_t e;
		if (arst_n && (!s_tvalid || in_took)) begin
			if (elem_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				e = elem_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= e.value;
				s_tlast <= e.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver with long hold-off on request
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		triple_t got, exp_r;
		if (m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.idx_a = m_tdata[6:1];
			got.idx_b = m_tdata[12:7];
			got.idx_c = m_tdata[18:13];
			got.ovf = m_tdata[19];
			if (triple_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, m_tdata);
				mismatches++;
			end else begin
				exp_r = triple_q.pop_front();
				if (got !== exp_r || m_tdata[23:20] !== 4'b0) begin
					$display("%0t: result mismatch expected %p actual %p (raw %h)",
						$time, exp_r, got, m_tdata);
					mismatches++;
				end
			end
		end
	end

	task automatic push_set(int n, int lo, int hi);
		elem_t e;
		for (int k = 0; k < n; k++) begin
			e.value = 16'($urandom_range(hi - lo) + lo);
			e.last = (k == n - 1);
			elem_q.push_back(e);
		end
	endtask

	task automatic push_one(int v, bit l);
		elem_t e;
		e.value = 16'(v);
		e.last = l;
		elem_q.push_back(e);
	endtask

	task automatic drain();
		while (elem_q.size() > 0 || s_tvalid || triple_q.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_target(int signed t);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= t[tss_pkg::TARGET_WIDTH-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		want_sum = t;
	endtask

	task automatic random_sets(int items);
		int n, sel, span;
		while (items > 0) begin
			sel = $urandom_range(99);
			if (sel < 3)
				n = NMAX + $urandom_range(4);
			else if (sel < 10)
				n = $urandom_range(2) + 1;
			else
				n = $urandom_range(10) + 3;
			if ($urandom_range(3) == 0) begin
				push_set(n, -32768, 32767);
			end else begin
				span = $urandom_range(40) + 2;
				push_set(n, want_sum / 3 - span, want_sum / 3 + span);
			end
			items -= n;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		set_target(0);
		push_one(1, 0); push_one(-1, 0); push_one(0, 1);
		push_one(5, 1);
		push_one(3, 0); push_one(-3, 1);
		push_one(2, 0); push_one(-1, 0); push_one(-1, 0); push_one(-1, 0); push_one(0, 1);
		push_one(7, 0); push_one(8, 0); push_one(9, 1);
		set_target(98301);
		push_one(32767, 0); push_one(32767, 0); push_one(32767, 1);
		set_target(-98304);
		push_one(-32768, 0); push_one(-32768, 0); push_one(-32768, 1);
		set_target(-131072);
		push_one(-32768, 0); push_one(0, 0); push_one(-1, 1);
		drain();
		set_target(131071);
		for (int k = 0; k < NMAX + 2; k++)
			push_one(k - 20, k == NMAX + 1);

		// random phases with different idle mixes
		send_idle = 0; recv_idle = 0;
		set_target(0);
		random_sets(100);
		send_idle = 51; recv_idle = 0;
		set_target(-40);
		random_sets(100);
		send_idle = 0; recv_idle = 51;
		set_target(30);
		random_sets(100);
		send_idle = 37; recv_idle = 37;
		set_target($urandom_range(200) - 100);
		random_sets(50);
		@(posedge clk);
		hold_kick = hold_kick + 1;
		random_sets(50);
		send_idle = 0; recv_idle = 0;
		set_target(98301);
		random_sets(20);
		drain();

		if (mismatches == 0 && triple_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
